// ===== rtl/terminal_escape_sequence_parser_defines.svh =====
// Assertion macros for the terminal escape sequence parser
`ifndef TERMINAL_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH
`define TERMINAL_ESCAPE_SEQUENCE_PARSER_DEFINES_SVH
`define TESP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define TESP_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ===== rtl/tesp_pkg.sv =====
// Shared types and constants of the terminal escape sequence parser
`timescale 1ns / 1ps
package tesp_pkg;
  localparam logic [7:0] ByteEsc = 8'h1B;
  localparam logic [7:0] ByteCan = 8'h18;
  localparam logic [7:0] ByteSub = 8'h1A;
  localparam logic [7:0] ByteCsi = 8'h5B;
  localparam logic [7:0] ByteOsc = 8'h5D;
  localparam logic [7:0] BytePm  = 8'h5E;
  localparam logic [7:0] ByteApc = 8'h5F;
  localparam logic [7:0] ByteDcs = 8'h50;
  localparam logic [7:0] ByteSt  = 8'h5C;
  localparam logic [7:0] ByteDel = 8'h7F;
  localparam logic [7:0] ByteSemi = 8'h3B;
  localparam int unsigned MaxEv = 4;
  localparam int unsigned QDepth = 4;

  typedef enum logic [3:0] {
    EvPrint = 4'd0, EvCtl = 4'd1, EvType = 4'd2, EvParam = 4'd3, EvInter = 4'd4,
    EvData = 4'd5, EvFinal = 4'd6, EvEnd = 4'd7, EvCancel = 4'd8
  } ev_kind_e;

  typedef enum logic [11:0] {
    StGround = 12'h001, StEsc = 12'h002, StEscInt = 12'h004, StCsi = 12'h008,
    StCsiInt = 12'h010, StDcs = 12'h020, StDcsInt = 12'h040, StDcsData = 12'h080,
    StDcsEsc = 12'h100, StOsc = 12'h200, StPm = 12'h400, StApc = 12'h800
  } pstate_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [20:0] value;
    logic [1:0]  title;
  } event_t;

  typedef struct packed {
    logic [2:0]          count;
    event_t [MaxEv-1:0] ev;
  } bundle_t;

  function automatic logic is_ctl(input logic [7:0] b);
    return b == 8'h05 || (b >= 8'h07 && b <= 8'h0F) || b == 8'h11 || b == 8'h13;
  endfunction
endpackage

// ===== rtl/tesp_front.sv =====
// Front end: parse state machine, UTF-8 decoding and event classification
`timescale 1ns / 1ps
module tesp_front import tesp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic [20:0] err_char_i,
  output bundle_t     bundle_o
);
  pstate_e     st_q, st_d;
  logic [20:0] acc_q, acc_d;
  logic [2:0]  need_q, need_d, len_q, len_d;
  logic [7:0]  ofirst_q, ofirst_d;
  logic [1:0]  ocnt_q, ocnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StGround;
      acc_q <= '0;
      need_q <= '0;
      len_q <= '0;
      ofirst_q <= '0;
      ocnt_q <= '0;
    end else if (step_i) begin
      st_q <= st_d;
      acc_q <= acc_d;
      need_q <= need_d;
      len_q <= len_d;
      ofirst_q <= ofirst_d;
      ocnt_q <= ocnt_d;
    end
  end

  always_comb begin
    bundle_t     bo;
    logic [7:0]  b;
    logic        fits;
    logic [1:0]  ttl;
    logic        esc_in;
    bo = '0;
    b = byte_i;
    st_d = st_q;
    acc_d = acc_q;
    need_d = need_q;
    len_d = len_q;
    ofirst_d = ofirst_q;
    ocnt_d = ocnt_q;
    fits = 1'b0;
    ttl = 2'd3;
    esc_in = 1'b0;
    for (int i = 0; i < MaxEv; i++) bo.ev[i].title = 2'd3;
    if (b != 8'h00) begin
      if (st_q == StDcsEsc) begin
        if (b == ByteSt) begin
          bo.ev[0].kind = EvEnd; bo.ev[0].value = 21'(b); bo.count = 3'd1;
          st_d = StGround;
        end else begin
          bo.ev[0].kind = EvCancel; bo.ev[0].value = 21'd3; bo.count = 3'd1;
          esc_in = 1'b1;
        end
      end
      if (st_q == StEsc || esc_in) begin
        st_d = StEsc;
        if (b == ByteEsc) begin
          bo.ev[bo.count].kind = EvCancel; bo.ev[bo.count].value = 21'd3;
          bo.count = bo.count + 3'd1;
        end else if (b == ByteCan) begin
          bo.ev[bo.count].kind = EvCancel; bo.ev[bo.count].value = 21'd0;
          bo.count = bo.count + 3'd1; st_d = StGround;
        end else if (b == ByteSub) begin
          bo.ev[bo.count].kind = EvCancel; bo.ev[bo.count].value = 21'd1;
          bo.ev[bo.count+1].kind = EvPrint; bo.ev[bo.count+1].value = err_char_i;
          bo.count = bo.count + 3'd2; st_d = StGround;
        end else if (is_ctl(b)) begin
          bo.ev[bo.count].kind = EvCtl; bo.ev[bo.count].value = 21'(b);
          bo.count = bo.count + 3'd1;
        end else if (b == ByteCsi || b == ByteOsc || b == BytePm || b == ByteApc
                     || b == ByteDcs) begin
          bo.ev[bo.count].kind = EvType;
          unique case (b)
            ByteCsi: begin bo.ev[bo.count].value = 21'd1; st_d = StCsi; end
            ByteOsc: begin
              bo.ev[bo.count].value = 21'd3; st_d = StOsc; ofirst_d = '0; ocnt_d = '0;
            end
            BytePm:  begin bo.ev[bo.count].value = 21'd4; st_d = StPm; end
            ByteApc: begin bo.ev[bo.count].value = 21'd5; st_d = StApc; end
            default: begin bo.ev[bo.count].value = 21'd2; st_d = StDcs; end
          endcase
          bo.count = bo.count + 3'd1;
        end else if (b >= 8'h20 && b <= 8'h7E) begin
          bo.ev[bo.count].kind = EvType; bo.ev[bo.count].value = 21'd0;
          bo.ev[bo.count+1].kind = (b <= 8'h2F) ? EvInter : EvFinal;
          bo.ev[bo.count+1].value = 21'(b);
          bo.count = bo.count + 3'd2;
          st_d = (b <= 8'h2F) ? StEscInt : StGround;
        end else if (b != ByteDel) begin
          bo.ev[bo.count].kind = EvCancel; bo.ev[bo.count].value = 21'd2;
          bo.count = bo.count + 3'd1; st_d = StGround;
        end
      end else begin
        unique case (st_q)
          StGround: begin
            if (b == ByteEsc || b == ByteCan || b == ByteSub || is_ctl(b)) begin
              if (need_q != 3'd0) begin
                bo.ev[0].kind = EvPrint; bo.ev[0].value = err_char_i; bo.count = 3'd1;
                acc_d = '0; need_d = '0; len_d = '0;
              end
              if (b == ByteEsc) st_d = StEsc;
              else if (b == ByteSub) begin
                bo.ev[bo.count].kind = EvPrint; bo.ev[bo.count].value = err_char_i;
                bo.count = bo.count + 3'd1;
              end else if (b != ByteCan) begin
                bo.ev[bo.count].kind = EvCtl; bo.ev[bo.count].value = 21'(b);
                bo.count = bo.count + 3'd1;
              end
            end else begin
              fits = (b[7:6] == 2'b10);
              if (len_q == 3'd3 && need_q == 3'd2) begin
                if (acc_q == 21'd0 && b < 8'hA0) fits = 1'b0;
                if (acc_q == 21'hD && b > 8'h9F) fits = 1'b0;
              end
              if (len_q == 3'd4 && need_q == 3'd3) begin
                if (acc_q == 21'd0 && b < 8'h90) fits = 1'b0;
                if (acc_q == 21'd4 && b > 8'h8F) fits = 1'b0;
              end
              if (need_q != 3'd0 && fits) begin
                acc_d = {acc_q[14:0], b[5:0]};
                need_d = need_q - 3'd1;
                if (need_q == 3'd1) begin
                  bo.ev[0].kind = EvPrint; bo.ev[0].value = acc_d; bo.count = 3'd1;
                  acc_d = '0; need_d = '0; len_d = '0;
                end
              end else begin
                if (need_q != 3'd0) begin
                  bo.ev[0].kind = EvPrint; bo.ev[0].value = err_char_i; bo.count = 3'd1;
                  acc_d = '0; need_d = '0; len_d = '0;
                end
                if (b < 8'h80) begin
                  bo.ev[bo.count].kind = EvPrint; bo.ev[bo.count].value = 21'(b);
                  bo.count = bo.count + 3'd1;
                end else if (b >= 8'hC2 && b <= 8'hDF) begin
                  acc_d = 21'(b[4:0]); need_d = 3'd1; len_d = 3'd2;
                end else if (b >= 8'hE0 && b <= 8'hEF) begin
                  acc_d = 21'(b[3:0]); need_d = 3'd2; len_d = 3'd3;
                end else if (b >= 8'hF0 && b <= 8'hF4) begin
                  acc_d = 21'(b[2:0]); need_d = 3'd3; len_d = 3'd4;
                end else begin
                  bo.ev[bo.count].kind = EvPrint; bo.ev[bo.count].value = err_char_i;
                  bo.count = bo.count + 3'd1;
                end
              end
            end
          end
          StEscInt, StCsi, StCsiInt, StDcs, StDcsInt, StDcsData: begin
            bo.count = 3'd1;
            bo.ev[0].value = 21'(b);
            if (b == ByteEsc) begin
              if (st_q == StDcs || st_q == StDcsInt || st_q == StDcsData) begin
                bo.count = 3'd0; st_d = StDcsEsc;
              end else begin
                bo.ev[0].kind = EvCancel; bo.ev[0].value = 21'd3; st_d = StEsc;
              end
            end else if (b == ByteCan) begin
              bo.ev[0].kind = EvCancel; bo.ev[0].value = 21'd0; st_d = StGround;
            end else if (b == ByteSub) begin
              bo.ev[0].kind = EvCancel; bo.ev[0].value = 21'd1;
              bo.ev[1].kind = EvPrint; bo.ev[1].value = err_char_i;
              bo.count = 3'd2; st_d = StGround;
            end else if (is_ctl(b)) begin
              bo.ev[0].kind = EvCtl;
            end else if (st_q == StDcsData) begin
              bo.ev[0].kind = EvData;
            end else if (st_q == StEscInt) begin
              if (b >= 8'h20 && b <= 8'h2F) bo.ev[0].kind = EvInter;
              else if (b >= 8'h30 && b <= 8'h7E) begin
                bo.ev[0].kind = EvFinal; st_d = StGround;
              end else if (b == ByteDel) bo.count = 3'd0;
              else begin
                bo.ev[0].kind = EvCancel; bo.ev[0].value = 21'd2; st_d = StGround;
              end
            end else begin
              if ((st_q == StCsi || st_q == StDcs) && b >= 8'h30 && b <= 8'h3F)
                bo.ev[0].kind = EvParam;
              else if (b >= 8'h20 && b <= 8'h2F) begin
                bo.ev[0].kind = EvInter;
                st_d = (st_q == StCsi || st_q == StCsiInt) ? StCsiInt : StDcsInt;
              end else if (b >= 8'h40 && b <= 8'h7E) begin
                bo.ev[0].kind = EvFinal;
                st_d = (st_q == StCsi || st_q == StCsiInt) ? StGround : StDcsData;
              end else begin
                bo.ev[0].kind = EvCancel; bo.ev[0].value = 21'd2; st_d = StGround;
              end
            end
          end
          StOsc, StPm, StApc: begin
            bo.count = 3'd1;
            bo.ev[0].value = 21'(b);
            if (b == ByteCan) begin
              bo.ev[0].kind = EvCancel; bo.ev[0].value = 21'd0; st_d = StGround;
            end else if (b == ByteSub) begin
              bo.ev[0].kind = EvCancel; bo.ev[0].value = 21'd1;
              bo.ev[1].kind = EvPrint; bo.ev[1].value = err_char_i;
              bo.count = 3'd2; st_d = StGround;
            end else if (b == ByteEsc || is_ctl(b)) begin
              if (st_q == StOsc && ocnt_q == 2'd2 && ofirst_q >= 8'h30 && ofirst_q <= 8'h32)
                ttl = ofirst_q[1:0];
              bo.ev[0].kind = EvEnd; bo.ev[0].title = ttl; st_d = StGround;
            end else begin
              if (st_q == StOsc) begin
                if (ocnt_q == 2'd0) begin
                  ofirst_d = b; ocnt_d = 2'd1;
                end else if (ocnt_q == 2'd1) ocnt_d = (b == ByteSemi) ? 2'd2 : 2'd3;
              end
              bo.ev[0].kind = EvData;
            end
          end
          default: st_d = StGround;
        endcase
      end
    end
    bundle_o = bo;
  end
endmodule

// ===== rtl/tesp_queue.sv =====
// Bundle queue between the front end and the event sequencer
`timescale 1ns / 1ps
module tesp_queue import tesp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_i,
  input  bundle_t wdata_i,
  output logic    full_o,
  input  logic    rd_i,
  output logic    empty_o,
  output bundle_t rdata_o
);
  localparam int unsigned Aw = $clog2(QDepth);
  bundle_t         mem_q [QDepth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     cnt_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wp_q] <= wdata_i;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i) wp_q <= wp_q + 1'b1;
      if (rd_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(wr_i) - (Aw+1)'(rd_i);
    end
  end
  assign full_o = cnt_q == (Aw+1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];
endmodule

// ===== rtl/tesp_back.sv =====
// Back end: steps through the events of each bundle onto the result ports
`timescale 1ns / 1ps
module tesp_back import tesp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  bundle_t     q_data_i,
  output logic        q_rd_o,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  event_kind_o,
  output logic [20:0] event_value_o,
  output logic [1:0]  title_target_o,
  output logic        last_event_o
);
  logic [1:0] idx_q, idx_d;
  event_t     cur;
  logic       last;

  assign cur = q_data_i.ev[idx_q];
  assign last = (3'(idx_q) + 3'd1) == q_data_i.count;
  assign empty = q_empty_i;
  assign q_rd_o = !q_empty_i && pop && last;
  assign event_kind_o = cur.kind;
  assign event_value_o = cur.value;
  assign title_target_o = cur.title;
  assign last_event_o = last;

  always_comb begin
    idx_d = idx_q;
    if (!q_empty_i && pop) idx_d = last ? 2'd0 : idx_q + 2'd1;
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else idx_q <= idx_d;
  end
endmodule

// ===== rtl/terminal_escape_sequence_parser.sv =====
// Top level of the terminal escape sequence parser
// Takes one terminal byte per cycle (NUL is dropped) and parses it at once; each byte's
// one to three events go into a four-entry queue and drain through the result port one
// per pop, the last one flagged. Input stalls only when that queue is full, so the
// sustained rate is one byte per cycle as long as each byte yields at most one event.
`timescale 1ns / 1ps
`include "terminal_escape_sequence_parser_defines.svh"
module terminal_escape_sequence_parser import tesp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  event_kind_o,
  output logic [20:0] event_value_o,
  output logic [1:0]  title_target_o,
  output logic        last_event_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [20:0] cfg_data_i
);
  logic [20:0] err_q;
  bundle_t     bnd, qd;
  logic        step, q_rd, q_empty;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) err_q <= 21'h00FFFD;
    else if (cfg_valid) err_q <= cfg_data_i;
  end

  assign step = push && !full;

  tesp_front u_front (
    .clk_i, .rst_ni, .step_i(step), .byte_i(rx_byte_i), .err_char_i(err_q), .bundle_o(bnd)
  );
  tesp_queue u_queue (
    .clk_i, .rst_ni, .wr_i(step && bnd.count != 3'd0), .wdata_i(bnd), .full_o(full),
    .rd_i(q_rd), .empty_o(q_empty), .rdata_o(qd)
  );
  tesp_back u_back (
    .clk_i, .rst_ni, .q_empty_i(q_empty), .q_data_i(qd), .q_rd_o(q_rd), .empty, .pop,
    .event_kind_o, .event_value_o, .title_target_o, .last_event_o
  );

  `TESP_ASSERT(a_no_pop_empty, q_rd |-> !q_empty, "dequeue from empty queue")
  `TESP_ASSERT(a_kind_range, !empty |-> event_kind_o <= 4'd8, "bad event kind")
  `TESP_ASSERT_RST(a_rst_empty, !rst_ni |-> empty, "results during reset")
endmodule
